// ===== src/gnn_pkg.sv =====
`timescale 1ns / 1ps
package gnn_pkg;
    localparam int MAX_NODES = 4096;
    localparam int ADDR_W = $clog2(MAX_NODES);
    localparam int FRAC_BITS = 8;
    localparam int GRAD_W = 16;
    localparam int STORE_W = 3 * GRAD_W;

    localparam logic CMD_LOAD = 1'b0;
    localparam logic CMD_EVAL = 1'b1;

    localparam logic [2:0] REG_DIMS = 3'd0;
    localparam logic [2:0] REG_SIZE0 = 3'd1;
    localparam logic [2:0] REG_SIZE1 = 3'd2;
    localparam logic [2:0] REG_SIZE2 = 3'd3;
    localparam logic [2:0] REG_MODE = 3'd4;

    localparam logic [1:0] MODE_LINEAR = 2'd0;
    localparam logic [1:0] MODE_CUBIC = 2'd1;

    typedef logic signed [47:0] t_acc;

    function automatic logic [4:0] clamp_size(input logic [4:0] s);
        logic [4:0] r;
        begin
            if (s < 5'd2) begin
                r = 5'd2;
            end else if (s > 5'd16) begin
                r = 5'd16;
            end else begin
                r = s;
            end
            return r;
        end
    endfunction
endpackage

// ===== src/gradient_noise_nd_eval.sv =====
// Load transaction: writes the gradient to the store, busy stays low and no result follows.
// Evaluate transaction: reduce each cell index modulo (size - 1) by repeated subtraction,
// then per corner over 2^d corners a read and a dot-product step per dimension, then per
// dimension a fade step (linear, cubic, quintic) and its lerps, and one output state; the
// one-cycle strobe comes in the next cycle. One evaluation at a time; synchronous active-low
// reset restores the state, strobe and configuration registers, not the store.
`timescale 1ns / 1ps
module gradient_noise_nd_eval
    import gnn_pkg::*;
(
    input  logic               i_clk,
    input  logic               i_rst_n,
    input  logic               start,
    output logic               busy,
    input  logic               i_cmd,
    input  logic [11:0]        i_node_index,
    input  logic signed [15:0] i_grad_x,
    input  logic signed [15:0] i_grad_y,
    input  logic signed [15:0] i_grad_z,
    input  logic [15:0]        i_coord_0,
    input  logic [15:0]        i_coord_1,
    input  logic [15:0]        i_coord_2,
    output logic               o_valid,
    output logic signed [17:0] o_noise_value,
    input  logic               psel,
    input  logic               penable,
    input  logic               pwrite,
    input  logic [4:0]         paddr,
    input  logic [31:0]        pwdata,
    output logic [31:0]        prdata,
    output logic               pready
);
    localparam logic [3:0] S_IDLE = 4'd0;
    localparam logic [3:0] S_BASE = 4'd1;
    localparam logic [3:0] S_FADE = 4'd2;
    localparam logic [3:0] S_READ = 4'd3;
    localparam logic [3:0] S_DOT = 4'd4;
    localparam logic [3:0] S_LERP = 4'd5;
    localparam logic [3:0] S_OUT = 4'd6;

    logic [1:0] r_dims;
    logic [4:0] r_size [3];
    logic [1:0] r_mode;

    logic [3:0] r_state;
    logic [1:0] r_d;
    logic [13:0] r_t [3];
    logic [7:0] r_ip [3];
    logic [11:0] r_base;
    logic [11:0] r_stride [3];
    logic [1:0] r_k;
    logic [3:0] r_i;
    logic [2:0] r_step;
    t_acc r_vals [8];
    logic [14:0] r_w;
    logic [47:0] r_x;
    logic [15:0] r_g [3];
    logic [3:0] r_cnt;
    logic [3:0] r_j;
    logic r_valid;
    logic signed [17:0] r_out;

    logic cfg_wr;
    logic ram_we;
    logic [ADDR_W-1:0] ram_addr;
    logic [STORE_W-1:0] ram_rdata;
    logic [3:0] n_corner;

    assign pready = 1'b1;
    assign cfg_wr = psel && penable && pwrite;
    assign busy = (r_state != S_IDLE);
    assign o_valid = r_valid;
    assign o_noise_value = r_out;

    always_comb begin
        unique case (paddr[4:2])
            REG_DIMS: prdata = {30'd0, r_dims};
            REG_SIZE0: prdata = {27'd0, r_size[0]};
            REG_SIZE1: prdata = {27'd0, r_size[1]};
            REG_SIZE2: prdata = {27'd0, r_size[2]};
            REG_MODE: prdata = {30'd0, r_mode};
            default: prdata = 32'd0;
        endcase
    end

    function automatic logic [11:0] corner_addr(input logic [3:0] i, input logic [11:0] b,
                                                input logic [11:0] s0, input logic [11:0] s1,
                                                input logic [11:0] s2);
        logic [11:0] a;
        begin
            a = b;
            if (i[0]) a = a + s0;
            if (i[1]) a = a + s1;
            if (i[2]) a = a + s2;
            return a;
        end
    endfunction

    assign n_corner = r_i;
    assign ram_we = (r_state == S_IDLE) && start && (i_cmd == CMD_LOAD);
    assign ram_addr = ram_we ? i_node_index[ADDR_W-1:0]
                             : corner_addr(n_corner, r_base, r_stride[0], r_stride[1],
                                           r_stride[2]);

    gnn_ram #(.WIDTH(STORE_W), .DEPTH(MAX_NODES)) u_store (
        .i_clk  (i_clk),
        .i_we   (ram_we),
        .i_addr (ram_addr),
        .i_wdata({i_grad_z, i_grad_y, i_grad_x}),
        .o_rdata(ram_rdata)
    );

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_dims <= 2'd3;
            r_size[0] <= 5'd2;
            r_size[1] <= 5'd2;
            r_size[2] <= 5'd2;
            r_mode <= 2'd2;
        end else if (cfg_wr) begin
            unique case (paddr[4:2])
                REG_DIMS: r_dims <= pwdata[1:0];
                REG_SIZE0: r_size[0] <= pwdata[4:0];
                REG_SIZE1: r_size[1] <= pwdata[4:0];
                REG_SIZE2: r_size[2] <= pwdata[4:0];
                REG_MODE: r_mode <= pwdata[1:0];
                default: ;
            endcase
        end
    end

    // Sequencer for the evaluate transaction.
    logic [4:0] sz;
    logic [7:0] rem;
    logic [13:0] tk;
    logic signed [15:0] pos;
    logic signed [15:0] gk;
    logic signed [31:0] dprod;
    t_acc dif;
    t_acc prod;
    always_comb begin
        sz = clamp_size(r_size[r_k]) - 5'd1;
        rem = r_ip[r_k];
        tk = r_t[r_k];
        pos = $signed({2'b00, tk}) - (r_i[r_k] ? 16'sd16384 : 16'sd0);
        gk = (r_k == 2'd0) ? ram_rdata[15:0] : r_g[r_k];
        dprod = pos * gk;
        dif = r_vals[{r_j[1:0], 1'b1}] - r_vals[{r_j[1:0], 1'b0}];
        prod = dif * $signed({1'b0, r_w});
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= S_IDLE;
            r_valid <= 1'b0;
        end else begin
            r_valid <= 1'b0;
            unique case (r_state)
                S_IDLE: begin
                    if (start && i_cmd == CMD_EVAL) begin
                        r_d <= (r_dims == 2'd0) ? 2'd1 : r_dims;
                        r_ip[0] <= i_coord_0[15:8];
                        r_ip[1] <= i_coord_1[15:8];
                        r_ip[2] <= i_coord_2[15:8];
                        r_t[0] <= {i_coord_0[7:0], 6'd0};
                        r_t[1] <= {i_coord_1[7:0], 6'd0};
                        r_t[2] <= {i_coord_2[7:0], 6'd0};
                        r_base <= 12'd0;
                        r_stride[0] <= 12'd1;
                        r_stride[1] <= 12'd0;
                        r_stride[2] <= 12'd0;
                        r_k <= 2'd0;
                        r_state <= S_BASE;
                    end
                end
                S_BASE: begin
                    // Iterative remainder: subtract size-1 until below.
                    if (rem >= {3'd0, sz}) begin
                        r_ip[r_k] <= rem - {3'd0, sz};
                    end else begin
                        r_base <= r_base + 12'(rem) * r_stride[r_k];
                        if (r_k < 2'd2) begin
                            r_stride[r_k + 2'd1] <= r_stride[r_k] * 12'(sz + 5'd1);
                        end
                        for (int m = 0; m < 8; m++) begin
                            r_vals[m] <= '0;
                        end
                        if (r_k + 2'd1 == r_d) begin
                            r_i <= 4'd0;
                            r_state <= S_READ;
                        end else begin
                            r_k <= r_k + 2'd1;
                        end
                    end
                end
                S_READ: begin
                    r_k <= 2'd0;
                    r_state <= S_DOT;
                end
                S_DOT: begin
                    if (r_k == 2'd0) begin
                        r_g[0] <= ram_rdata[15:0];
                        r_g[1] <= ram_rdata[31:16];
                        r_g[2] <= ram_rdata[47:32];
                        r_vals[r_i[2:0]] <= t_acc'(dprod);
                    end else begin
                        r_vals[r_i[2:0]] <= r_vals[r_i[2:0]] + t_acc'(dprod);
                    end
                    if (r_k + 2'd1 == r_d) begin
                        if (r_i + 4'd1 == (4'd1 << r_d)) begin
                            r_k <= 2'd0;
                            r_step <= 3'd0;
                            r_state <= S_FADE;
                        end else begin
                            r_i <= r_i + 4'd1;
                            r_state <= S_READ;
                        end
                    end else begin
                        r_k <= r_k + 2'd1;
                    end
                end
                S_FADE: begin
                    unique case (r_step)
                        3'd0: begin
                            if (r_mode == MODE_LINEAR) begin
                                r_w <= {1'b0, tk};
                                r_j <= 4'd0;
                                r_cnt <= (4'd1 << r_d) >> (r_k + 2'd1);
                                r_state <= S_LERP;
                            end else if (r_mode == MODE_CUBIC) begin
                                r_x <= 48'(49152 - 2 * 32'(tk));
                                r_step <= 3'd4;
                            end else begin
                                r_x <= 48'($signed(6 * 32'(tk)) - 32'sd245760);
                                r_step <= 3'd1;
                            end
                        end
                        3'd1: begin
                            r_x <= 48'($signed(r_x) * $signed({18'd0, tk}) + 48'sd2684354560);
                            r_step <= 3'd2;
                        end
                        3'd2: begin
                            r_x <= (r_x >> 14) * 48'(tk);
                            r_step <= 3'd3;
                        end
                        3'd3: begin
                            r_x <= r_x * 48'(tk);
                            r_step <= 3'd5;
                        end
                        3'd4: begin
                            r_x <= r_x * 48'(tk);
                            r_step <= 3'd6;
                        end
                        3'd5: begin
                            r_x <= 48'((64'(r_x) * 64'(tk) + 64'h200_0000_0000) >> 42);
                            r_step <= 3'd7;
                        end
                        3'd6: begin
                            r_x <= (r_x * 48'(tk) + 48'h800_0000) >> 28;
                            r_step <= 3'd7;
                        end
                        default: begin
                            r_w <= r_x[14:0];
                            r_j <= 4'd0;
                            r_cnt <= (4'd1 << r_d) >> (r_k + 2'd1);
                            r_state <= S_LERP;
                        end
                    endcase
                end
                S_LERP: begin
                    r_vals[r_j[2:0]] <= r_vals[{r_j[1:0], 1'b0}] + (prod >>> 14);
                    if (r_j + 4'd1 == r_cnt) begin
                        if (r_k + 2'd1 == r_d) begin
                            r_state <= S_OUT;
                        end else begin
                            r_k <= r_k + 2'd1;
                            r_step <= 3'd0;
                            r_state <= S_FADE;
                        end
                    end else begin
                        r_j <= r_j + 4'd1;
                    end
                end
                S_OUT: begin
                    if (((r_vals[0] + 48'sd8192) >>> 14) > 48'sd131071) begin
                        r_out <= 18'sd131071;
                    end else if (((r_vals[0] + 48'sd8192) >>> 14) < -48'sd131072) begin
                        r_out <= -18'sd131072;
                    end else begin
                        r_out <= 18'((r_vals[0] + 48'sd8192) >>> 14);
                    end
                    r_valid <= 1'b1;
                    r_state <= S_IDLE;
                end
                default: r_state <= S_IDLE;
            endcase
        end
    end

    a_valid_idle: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_valid |-> r_state == S_IDLE) else $error("result outside idle");
    a_out_from: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_valid |-> $past(r_state) == S_OUT) else $error("stray result");
    a_no_write_busy: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        ram_we |-> !busy) else $error("store write while busy");
endmodule

// ===== src/gnn_ram.sv =====
`timescale 1ns / 1ps
module gnn_ram #(
    parameter int WIDTH = 8,
    parameter int DEPTH = 16
) (
    input  logic                     i_clk,
    input  logic                     i_we,
    input  logic [$clog2(DEPTH)-1:0] i_addr,
    input  logic [WIDTH-1:0]         i_wdata,
    output logic [WIDTH-1:0]         o_rdata
);
    logic [WIDTH-1:0] r_mem [DEPTH];

    always_ff @(posedge i_clk) begin
        if (i_we) begin
            r_mem[i_addr] <= i_wdata;
        end
        o_rdata <= r_mem[i_addr];
    end
endmodule
